[rtl/core/bth_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_pkg
// Types, codes and helper functions shared by the boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package bth_pkg;

  // signed offset wide enough for every tag sum of the allocator
  localparam int unsigned OFF_W = 36;
  typedef logic signed [OFF_W-1:0] off_t;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_READ    = 2'd2,
    ACT_WRITE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FAIL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_STATUS,
    EM_PTR,
    EM_BYTE
  } emit_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_CLEAR,
    OP_BYTE_WR,
    OP_RD_ISSUE,
    OP_RD_CAPT,
    OP_WR_LANE,
    OP_RB_INIT,
    OP_RB_ISSUE,
    OP_RB_CAPT,
    OP_RB_NEXT,
    OP_A_INIT,
    OP_A_FETCH,
    OP_A_TAG,
    OP_A_STEP,
    OP_A_W1,
    OP_A_W2,
    OP_A_W3,
    OP_A_W4,
    OP_TAG,
    OP_R_HDR,
    OP_R_BUF,
    OP_R_FTR,
    OP_R_WH,
    OP_R_WF,
    OP_R_NXT,
    OP_R_NMRG,
    OP_R_PREV,
    OP_R_PH,
    OP_R_PBUF,
    OP_R_WP
  } dp_op_e;

  typedef enum logic [5:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_WR_BYTE,
    S_RB_INIT,
    S_RB_ISSUE,
    S_RB_CAPT,
    S_RB_EMIT,
    S_A_INIT,
    S_A_CHECK,
    S_A_TAG,
    S_A_TEST,
    S_A_W1,
    S_A_W2,
    S_A_W3,
    S_A_W4,
    S_R_HDR,
    S_R_BUF,
    S_R_FTR,
    S_R_WH,
    S_R_WF1,
    S_R_NXT,
    S_R_NXT_CHK,
    S_R_NT,
    S_R_NT_CHK,
    S_R_NMRG,
    S_R_WH2,
    S_R_WF2,
    S_R_PCHK,
    S_R_PREV,
    S_R_PT,
    S_R_PT_CHK,
    S_R_PH,
    S_R_PH_CHK,
    S_R_PBUF,
    S_R_WP,
    S_R_WF3,
    S_WRD_ISSUE,
    S_WRD_CAPT,
    S_WWR,
    S_EMIT_OK,
    S_EMIT_FAIL,
    S_EMIT_IGN,
    S_EMIT_PTR
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e  op;
    emit_e   emit;
    status_e code;
  } dp_cmd_t;

  typedef struct packed {
    logic    out_free;
    logic    lane_last;
    logic    clr_last;
    action_e act;
    logic    size_zero;
    logic    rel_bad;
    logic    cur_ge_heap;
    logic    fit;
    logic    rem_m4;
    logic    rem_ge0;
    logic    ptr_lt_heap;
    logic    t_neg;
    logic    hdr_ge4;
    logic    cur_neg;
    logic    rb_last;
  } dp_status_t;

  // round up to a multiple of four
  function automatic off_t up4(off_t v);
    off_t s;
    s = v + off_t'(3);
    return {s[OFF_W-1:2], 2'b00};
  endfunction

  // sign-extend a 32-bit tag
  function automatic off_t sext(logic [31:0] w);
    return {{(OFF_W-32){w[31]}}, w};
  endfunction

  // zero-extend a 32-bit value
  function automatic off_t zext(logic [31:0] w);
    return {{(OFF_W-32){1'b0}}, w};
  endfunction

endpackage

[rtl/core/bth_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_if
// Request and result channels of the heap allocator, valid/ready transfer.
// ----------------------------------------------------------------------------
interface bth_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] address;
  logic [12:0] size;
  logic [7:0]  data;

  modport source (output valid, action, address, size, data, input ready);
  modport sink (input valid, action, address, size, data, output ready);
endinterface

interface bth_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pointer;
  logic [7:0]  read_byte;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, pointer, read_byte, status, last, input ready);
  modport sink (input valid, pointer, read_byte, status, last, output ready);
endinterface

[rtl/core/boundary_tag_heap_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// First-fit heap with 32-bit header and footer tags around each block.
// ----------------------------------------------------------------------------
// Requests arrive on item_i (allocate, release, read bytes, write one byte)
// and results leave on result_o; both transfer when valid and ready are high.
// The heap sits in a byte-wide memory with one registered read port, so a
// tag word is read one byte at a time, each byte issued and then captured,
// and written one byte at a time. A read returns up to MAX_READ bytes;
// allocate walks the blocks in order and writes two or four tags, or fails
// when no block fits or the size is zero; release merges with a free next
// and a free previous block; a release outside the heap is ignored.
// One request is handled at a time; the next is taken once the last result
// is in the output register, even if the receiver has not taken it yet.
// After reset a clearing sweep writes every heap byte, one per cycle, and
// item_i.ready stays low until it ends.
// heap_base (cfg_we_i / cfg_wdata_i) resets to 8192 and may be written at
// any time the block is idle. A stalled receiver holds the result register
// and pauses the sequencer until it frees up.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator #(
  parameter int unsigned HEAP_BYTES = 4096,
  parameter int unsigned MAX_READ   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  bth_in_if.sink      item_i,
  bth_out_if.source   result_o
);
  import bth_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign item_i.ready = in_ready;

  // sequencer
  bth_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // heap store and arithmetic
  bth_datapath #(
    .HEAP_BYTES (HEAP_BYTES),
    .MAX_READ   (MAX_READ)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .action_i    (item_i.action),
    .address_i   (item_i.address),
    .size_i      (item_i.size),
    .data_i      (item_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result_o)
  );

endmodule

[rtl/core/bth_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_store
// Byte-wide heap memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bth_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/bth_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_datapath
// Heap store, tag arithmetic, word assembly and result register.
// ----------------------------------------------------------------------------
module bth_datapath #(
  parameter int unsigned HEAP_BYTES = 4096,
  parameter int unsigned MAX_READ   = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic [1:0]          action_i,
  input  logic [31:0]         address_i,
  input  logic [12:0]         size_i,
  input  logic [7:0]          data_i,
  input  bth_pkg::dp_cmd_t    cmd_i,
  output bth_pkg::dp_status_t status_o,
  bth_out_if.source           result_o
);
  import bth_pkg::*;

  localparam int unsigned AW       = $clog2(HEAP_BYTES);
  localparam int unsigned CW       = $clog2(MAX_READ + 1);
  localparam off_t        HEAP_OFF = off_t'(HEAP_BYTES);
  localparam logic [31:0] HEAP_W   = 32'(HEAP_BYTES);
  localparam logic [31:0] END_TAG  = 32'(HEAP_BYTES - 8);
  localparam logic [AW-1:0] HI_TAG = AW'(HEAP_BYTES - 4);
  localparam logic [AW-1:0] LAST_IDX = AW'(HEAP_BYTES - 1);
  localparam logic [CW-1:0] MAX_N  = CW'(MAX_READ);

  logic [31:0]   base_q, base_d;
  action_e       act_q, act_d;
  logic [31:0]   address_q, address_d;
  logic [12:0]   size_q, size_d;
  logic [7:0]    data_q, data_d;
  off_t          ptr_q, ptr_d;
  logic [1:0]    lane_q, lane_d;
  logic [31:0]   word_q, word_d;
  off_t          cur_q, cur_d;
  off_t          hdr_q, hdr_d;
  off_t          buf_q, buf_d;
  off_t          ftr_q, ftr_d;
  off_t          t_q, t_d;
  off_t          rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] n_q, n_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          rd_in_q, rd_in_d;
  logic          res_vld_q, res_vld_d;
  logic [31:0]   res_ptr_q, res_ptr_d;
  logic [7:0]    res_byte_q, res_byte_d;
  logic [1:0]    res_stat_q, res_stat_d;
  logic          res_last_q, res_last_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic [31:0]   rel_off;
  off_t          p_pos;
  logic          p_in;
  logic [31:0]   rb_off;
  logic          rb_in;
  off_t          t_up;
  off_t          t_mag;
  off_t          size_x;
  logic          rem_m4;
  logic [AW-1:0] clr_rel;
  logic [7:0]    clr_byte;
  logic [7:0]    cap_byte;
  logic          rb_last;

  // address arithmetic shared by the steps
  assign rel_off  = address_q - base_q;
  assign p_pos    = ptr_q + off_t'({{(OFF_W-2){1'b0}}, lane_q});
  assign p_in     = !p_pos[OFF_W-1] && (p_pos < HEAP_OFF);
  assign rb_off   = rel_off + {{(32-CW){1'b0}}, cnt_q};
  assign rb_in    = rb_off < HEAP_W;
  assign t_up     = up4(t_q);
  assign t_mag    = t_q[OFF_W-1] ? -t_q : t_q;
  assign size_x   = off_t'({{(OFF_W-13){1'b0}}, size_q});
  assign rem_m4   = rem_q == -off_t'(4);
  assign cap_byte = rd_in_q ? mem_rdata : 8'd0;
  assign rb_last  = (cnt_q + CW'(1)) == n_q;

  // initial tag bytes for the clearing sweep
  assign clr_rel = clr_q - HI_TAG;
  always_comb begin
    if (clr_q < AW'(4)) begin
      clr_byte = END_TAG[8*clr_q[1:0] +: 8];
    end else if (clr_q >= HI_TAG) begin
      clr_byte = END_TAG[8*clr_rel[1:0] +: 8];
    end else begin
      clr_byte = 8'd0;
    end
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p_pos[AW-1:0];
    mem_wdata = word_q[8*lane_q +: 8];
    mem_raddr = p_pos[AW-1:0];
    case (cmd_i.op)
      OP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = clr_byte;
      end
      OP_BYTE_WR: begin
        mem_we    = rel_off < HEAP_W;
        mem_waddr = rel_off[AW-1:0];
        mem_wdata = data_q;
      end
      OP_WR_LANE: begin
        mem_we = p_in;
      end
      OP_RB_ISSUE: begin
        mem_raddr = rb_off[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  bth_store #(
    .DEPTH (HEAP_BYTES),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // register updates per command
  always_comb begin
    base_d    = cfg_we_i ? cfg_wdata_i : base_q;
    act_d     = act_q;
    address_d = address_q;
    size_d    = size_q;
    data_d    = data_q;
    ptr_d     = ptr_q;
    lane_d    = lane_q;
    word_d    = word_q;
    cur_d     = cur_q;
    hdr_d     = hdr_q;
    buf_d     = buf_q;
    ftr_d     = ftr_q;
    t_d       = t_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    n_d       = n_q;
    clr_d     = clr_q;
    rd_in_d   = rd_in_q;
    case (cmd_i.op)
      OP_LATCH: begin
        act_d     = action_e'(action_i);
        address_d = address_i;
        size_d    = size_i;
        data_d    = data_i;
      end
      OP_CLEAR: clr_d = clr_q + AW'(1);
      OP_RD_ISSUE: rd_in_d = p_in;
      OP_RD_CAPT: begin
        word_d[8*lane_q +: 8] = cap_byte;
        lane_d = lane_q + 2'd1;
      end
      OP_WR_LANE: lane_d = lane_q + 2'd1;
      OP_RB_INIT: begin
        cnt_d = '0;
        n_d   = (size_q > 13'(MAX_READ)) ? MAX_N : size_q[CW-1:0];
      end
      OP_RB_ISSUE: rd_in_d = rb_in;
      OP_RB_CAPT: word_d[7:0] = cap_byte;
      OP_RB_NEXT: cnt_d = cnt_q + CW'(1);
      OP_A_INIT: cur_d = '0;
      OP_A_FETCH: ptr_d = cur_q;
      OP_A_TAG: begin
        t_d   = sext(word_q);
        buf_d = up4(size_x);
        rem_d = sext(word_q) - up4(size_x) - off_t'(8);
      end
      OP_A_STEP: cur_d = cur_q + up4(t_mag) + off_t'(8);
      OP_A_W1: begin
        ptr_d  = cur_q;
        word_d = rem_m4 ? (32'd0 - t_q[31:0]) : (32'd0 - {19'd0, size_q});
      end
      OP_A_W2: ptr_d = rem_m4 ? (cur_q + t_q + off_t'(4)) : (cur_q + buf_q + off_t'(4));
      OP_A_W3: begin
        ptr_d  = cur_q + buf_q + off_t'(8);
        word_d = rem_q[31:0];
      end
      OP_A_W4: ptr_d = cur_q + buf_q + off_t'(12) + rem_q;
      OP_TAG: t_d = sext(word_q);
      OP_R_HDR: begin
        hdr_d = zext(rel_off) - off_t'(4);
        ptr_d = zext(rel_off) - off_t'(4);
      end
      OP_R_BUF: buf_d = up4(zext(32'd0 - word_q));
      OP_R_FTR: ftr_d = hdr_q + buf_q + off_t'(4);
      OP_R_WH: begin
        ptr_d  = hdr_q;
        word_d = buf_q[31:0];
      end
      OP_R_WF: begin
        ptr_d  = ftr_q;
        word_d = buf_q[31:0];
      end
      OP_R_NXT: ptr_d = hdr_q + buf_q + off_t'(8);
      OP_R_NMRG: begin
        ftr_d = ptr_q + t_up + off_t'(4);
        buf_d = buf_q + t_up + off_t'(8);
      end
      OP_R_PREV: ptr_d = hdr_q - off_t'(4);
      OP_R_PH: cur_d = hdr_q - off_t'(8) - t_up;
      OP_R_PBUF: buf_d = buf_q + t_up + off_t'(8);
      OP_R_WP: begin
        ptr_d  = cur_q;
        word_d = buf_q[31:0];
      end
      default: begin
      end
    endcase
  end

  // result register, loaded only while free
  always_comb begin
    res_vld_d  = res_vld_q && !result_o.ready;
    res_ptr_d  = res_ptr_q;
    res_byte_d = res_byte_q;
    res_stat_d = res_stat_q;
    res_last_d = res_last_q;
    case (cmd_i.emit)
      EM_STATUS: begin
        res_vld_d  = 1'b1;
        res_ptr_d  = '0;
        res_byte_d = '0;
        res_stat_d = cmd_i.code;
        res_last_d = 1'b1;
      end
      EM_PTR: begin
        res_vld_d  = 1'b1;
        res_ptr_d  = base_q + cur_q[31:0] + 32'd4;
        res_byte_d = '0;
        res_stat_d = ST_DONE;
        res_last_d = 1'b1;
      end
      EM_BYTE: begin
        res_vld_d  = 1'b1;
        res_ptr_d  = '0;
        res_byte_d = word_q[7:0];
        res_stat_d = ST_DONE;
        res_last_d = rb_last;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= 32'd8192;
      lane_q    <= '0;
      clr_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      base_q    <= base_d;
      lane_q    <= lane_d;
      clr_q     <= clr_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    address_q  <= address_d;
    size_q     <= size_d;
    data_q     <= data_d;
    ptr_q      <= ptr_d;
    word_q     <= word_d;
    cur_q      <= cur_d;
    hdr_q      <= hdr_d;
    buf_q      <= buf_d;
    ftr_q      <= ftr_d;
    t_q        <= t_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    n_q        <= n_d;
    rd_in_q    <= rd_in_d;
    res_ptr_q  <= res_ptr_d;
    res_byte_q <= res_byte_d;
    res_stat_q <= res_stat_d;
    res_last_q <= res_last_d;
  end

  // status toward the controller
  always_comb begin
    status_o.out_free    = !res_vld_q || result_o.ready;
    status_o.lane_last   = lane_q == 2'd3;
    status_o.clr_last    = clr_q == LAST_IDX;
    status_o.act         = act_q;
    status_o.size_zero   = size_q == 13'd0;
    status_o.rel_bad     = (address_q == 32'd0) || (rel_off < 32'd4) || (rel_off >= HEAP_W);
    status_o.cur_ge_heap = cur_q >= HEAP_OFF;
    status_o.fit         = t_q >= size_x;
    status_o.rem_m4      = rem_m4;
    status_o.rem_ge0     = !rem_q[OFF_W-1];
    status_o.ptr_lt_heap = ptr_q < HEAP_OFF;
    status_o.t_neg       = t_q[OFF_W-1];
    status_o.hdr_ge4     = hdr_q >= off_t'(4);
    status_o.cur_neg     = cur_q[OFF_W-1];
    status_o.rb_last     = rb_last;
  end

  assign result_o.valid     = res_vld_q;
  assign result_o.pointer   = res_ptr_q;
  assign result_o.read_byte = res_byte_q;
  assign result_o.status    = res_stat_q;
  assign result_o.last      = res_last_q;

endmodule

[rtl/core/bth_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_ctrl
// Sequencer for clearing, allocate walk, release merge and byte access.
// ----------------------------------------------------------------------------
module bth_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bth_pkg::dp_status_t status_i,
  output bth_pkg::dp_cmd_t    cmd_o
);
  import bth_pkg::*;

  ctrl_state_e state_q, state_d;
  ctrl_state_e ret_q, ret_d;

  // next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      S_CLEAR: if (status_i.clr_last) state_d = S_IDLE;
      S_IDLE: if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        case (status_i.act)
          ACT_ALLOC:   state_d = status_i.size_zero ? S_EMIT_FAIL : S_A_INIT;
          ACT_RELEASE: state_d = status_i.rel_bad ? S_EMIT_IGN : S_R_HDR;
          ACT_READ:    state_d = status_i.size_zero ? S_EMIT_OK : S_RB_INIT;
          default:     state_d = S_WR_BYTE;
        endcase
      end
      S_WR_BYTE: state_d = S_EMIT_OK;
      S_RB_INIT: state_d = S_RB_ISSUE;
      S_RB_ISSUE: state_d = S_RB_CAPT;
      S_RB_CAPT: state_d = S_RB_EMIT;
      S_RB_EMIT: begin
        if (status_i.out_free) state_d = status_i.rb_last ? S_IDLE : S_RB_ISSUE;
      end
      S_A_INIT: state_d = S_A_CHECK;
      S_A_CHECK: begin
        if (status_i.cur_ge_heap) begin
          state_d = S_EMIT_FAIL;
        end else begin
          ret_d   = S_A_TAG;
          state_d = S_WRD_ISSUE;
        end
      end
      S_A_TAG: state_d = S_A_TEST;
      S_A_TEST: state_d = status_i.fit ? S_A_W1 : S_A_CHECK;
      S_A_W1: begin
        ret_d   = S_A_W2;
        state_d = S_WWR;
      end
      S_A_W2: begin
        ret_d   = (status_i.rem_m4 || !status_i.rem_ge0) ? S_EMIT_PTR : S_A_W3;
        state_d = S_WWR;
      end
      S_A_W3: begin
        ret_d   = S_A_W4;
        state_d = S_WWR;
      end
      S_A_W4: begin
        ret_d   = S_EMIT_PTR;
        state_d = S_WWR;
      end
      S_R_HDR: begin
        ret_d   = S_R_BUF;
        state_d = S_WRD_ISSUE;
      end
      S_R_BUF: state_d = S_R_FTR;
      S_R_FTR: state_d = S_R_WH;
      S_R_WH: begin
        ret_d   = S_R_WF1;
        state_d = S_WWR;
      end
      S_R_WF1: begin
        ret_d   = S_R_NXT;
        state_d = S_WWR;
      end
      S_R_NXT: state_d = S_R_NXT_CHK;
      S_R_NXT_CHK: begin
        if (status_i.ptr_lt_heap) begin
          ret_d   = S_R_NT;
          state_d = S_WRD_ISSUE;
        end else begin
          state_d = S_R_PCHK;
        end
      end
      S_R_NT: state_d = S_R_NT_CHK;
      S_R_NT_CHK: state_d = status_i.t_neg ? S_R_PCHK : S_R_NMRG;
      S_R_NMRG: state_d = S_R_WH2;
      S_R_WH2: begin
        ret_d   = S_R_WF2;
        state_d = S_WWR;
      end
      S_R_WF2: begin
        ret_d   = S_R_PCHK;
        state_d = S_WWR;
      end
      S_R_PCHK: state_d = status_i.hdr_ge4 ? S_R_PREV : S_EMIT_OK;
      S_R_PREV: begin
        ret_d   = S_R_PT;
        state_d = S_WRD_ISSUE;
      end
      S_R_PT: state_d = S_R_PT_CHK;
      S_R_PT_CHK: state_d = status_i.t_neg ? S_EMIT_OK : S_R_PH;
      S_R_PH: state_d = S_R_PH_CHK;
      S_R_PH_CHK: state_d = status_i.cur_neg ? S_EMIT_OK : S_R_PBUF;
      S_R_PBUF: state_d = S_R_WP;
      S_R_WP: begin
        ret_d   = S_R_WF3;
        state_d = S_WWR;
      end
      S_R_WF3: begin
        ret_d   = S_EMIT_OK;
        state_d = S_WWR;
      end
      S_WRD_ISSUE: state_d = S_WRD_CAPT;
      S_WRD_CAPT: state_d = status_i.lane_last ? ret_q : S_WRD_ISSUE;
      S_WWR: if (status_i.lane_last) state_d = ret_q;
      S_EMIT_OK, S_EMIT_FAIL, S_EMIT_IGN, S_EMIT_PTR: begin
        if (status_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NOP;
    cmd_o.emit = EM_NONE;
    cmd_o.code = ST_DONE;
    case (state_q)
      S_CLEAR: cmd_o.op = OP_CLEAR;
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LATCH;
      end
      S_WR_BYTE: cmd_o.op = OP_BYTE_WR;
      S_RB_INIT: cmd_o.op = OP_RB_INIT;
      S_RB_ISSUE: cmd_o.op = OP_RB_ISSUE;
      S_RB_CAPT: cmd_o.op = OP_RB_CAPT;
      S_RB_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op   = OP_RB_NEXT;
          cmd_o.emit = EM_BYTE;
        end
      end
      S_A_INIT: cmd_o.op = OP_A_INIT;
      S_A_CHECK: cmd_o.op = OP_A_FETCH;
      S_A_TAG: cmd_o.op = OP_A_TAG;
      S_A_TEST: if (!status_i.fit) cmd_o.op = OP_A_STEP;
      S_A_W1: cmd_o.op = OP_A_W1;
      S_A_W2: cmd_o.op = OP_A_W2;
      S_A_W3: cmd_o.op = OP_A_W3;
      S_A_W4: cmd_o.op = OP_A_W4;
      S_R_HDR: cmd_o.op = OP_R_HDR;
      S_R_BUF: cmd_o.op = OP_R_BUF;
      S_R_FTR: cmd_o.op = OP_R_FTR;
      S_R_WH, S_R_WH2: cmd_o.op = OP_R_WH;
      S_R_WF1, S_R_WF2, S_R_WF3: cmd_o.op = OP_R_WF;
      S_R_NXT: cmd_o.op = OP_R_NXT;
      S_R_NT, S_R_PT: cmd_o.op = OP_TAG;
      S_R_NMRG: cmd_o.op = OP_R_NMRG;
      S_R_PREV: cmd_o.op = OP_R_PREV;
      S_R_PH: cmd_o.op = OP_R_PH;
      S_R_PBUF: cmd_o.op = OP_R_PBUF;
      S_R_WP: cmd_o.op = OP_R_WP;
      S_WRD_ISSUE: cmd_o.op = OP_RD_ISSUE;
      S_WRD_CAPT: cmd_o.op = OP_RD_CAPT;
      S_WWR: cmd_o.op = OP_WR_LANE;
      S_EMIT_OK: if (status_i.out_free) cmd_o.emit = EM_STATUS;
      S_EMIT_FAIL: begin
        if (status_i.out_free) begin
          cmd_o.emit = EM_STATUS;
          cmd_o.code = ST_FAIL;
        end
      end
      S_EMIT_IGN: begin
        if (status_i.out_free) begin
          cmd_o.emit = EM_STATUS;
          cmd_o.code = ST_IGNORED;
        end
      end
      S_EMIT_PTR: if (status_i.out_free) cmd_o.emit = EM_PTR;
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

endmodule
